[hw/rtl/oiem_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox package
// Sizes, command and status codes, and pointer helpers shared by the event
// mailbox RTL and its checker.
// ----------------------------------------------------------------------------
package oiem_pkg;

    // Geometry of the mailbox.
    localparam int RING_DEPTH = 64;
    localparam int NUM_TASKS  = 16;
    localparam int MSG_WIDTH  = 64;

    // Widths fixed by the interface.
    localparam int CMD_W   = 3;
    localparam int ID_W    = 4;
    localparam int DATA_W  = 64;
    localparam int STAT_W  = 3;
    localparam int MASK_W  = 16;

    // Widths derived from the geometry.
    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SLOT_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int STORE_DEPTH = NUM_TASKS * RING_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // Task that receives owner posts when no owner is registered.
    localparam logic [ID_W-1:0] FALLBACK_TASK = ID_W'(1);

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_POST_TO        = 3'd0,
        CMD_POST_OWNER     = 3'd1,
        CMD_GET            = 3'd2,
        CMD_PEEK           = 3'd3,
        CMD_OWNER_REGISTER = 3'd4,
        CMD_OWNER_FORCE    = 3'd5,
        CMD_OWNER_CLEAR    = 3'd6,
        CMD_OWNER_READ     = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NORING   = 3'd3,
        ST_CONFLICT = 3'd4
    } status_t;

    // Advance a ring pointer with wrap at the ring depth.
    function automatic ptr_t ring_next(input ptr_t p);
        ring_next = (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + ptr_t'(1);
    endfunction

    // Flat store address of one entry of one slot's ring.
    function automatic addr_t ring_addr(input slot_t s, input ptr_t p);
        ring_addr = addr_t'(s) * addr_t'(RING_DEPTH) + addr_t'(p);
    endfunction

endpackage

[hw/rtl/oiem_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data; the read data
// holds its value while no read is issued.
// ----------------------------------------------------------------------------
module oiem_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/owned_input_event_mailbox_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Owned input event mailbox
// Per-task message rings in one shared store, with an input owner register.
// ----------------------------------------------------------------------------
// A request is accepted in S_IDLE: the slot's head and tail pointers are
// checked and updated, a post writes the ring store and a get or peek starts
// a read. In S_RESP, once the output register is free, the registered read
// data of the ring store is combined with the status into the response, which
// is then held in the output register until it is taken. A new request can be
// accepted while an earlier response still waits at the output, but not while
// one is in S_RESP. The ring store needs no clearing after reset.
module owned_input_event_mailbox_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Ring present mask.
    input  logic                        cfg_we,
    input  logic [oiem_pkg::MASK_W-1:0] cfg_wdata,
    // Request channel.
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [oiem_pkg::CMD_W-1:0]  s_command,
    input  logic [oiem_pkg::ID_W-1:0]   s_task_id,
    input  logic [oiem_pkg::DATA_W-1:0] s_msg_data,
    // Response channel.
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [oiem_pkg::STAT_W-1:0] m_status,
    output logic [oiem_pkg::DATA_W-1:0] m_msg_out,
    output logic [oiem_pkg::ID_W-1:0]   m_owner_id
);

    typedef enum logic {
        S_IDLE,
        S_RESP
    } fsm_t;

    fsm_t state_reg;

    logic [oiem_pkg::MASK_W-1:0] mask_reg;
    logic [oiem_pkg::ID_W-1:0]   owner_reg, owner_next;
    oiem_pkg::ptr_t              head_reg [oiem_pkg::NUM_TASKS];
    oiem_pkg::ptr_t              tail_reg [oiem_pkg::NUM_TASKS];

    // Pending response fields captured at accept.
    oiem_pkg::status_t           stat_reg, stat_next;
    logic                        rdmsg_reg, rdmsg_next;

    // Output register.
    logic                        m_valid_reg;
    oiem_pkg::status_t           m_status_reg;
    logic [oiem_pkg::DATA_W-1:0] m_msg_reg;
    logic [oiem_pkg::ID_W-1:0]   m_owner_reg;

    oiem_pkg::cmd_t              cmd;
    logic                        accept;
    logic [oiem_pkg::ID_W-1:0]   tgt_id;
    logic                        slot_ok;
    oiem_pkg::slot_t             slot;
    oiem_pkg::ptr_t              head_cur, tail_cur, head_nx, tail_nx;
    logic                        ring_empty, ring_full;
    logic                        head_inc, tail_inc;
    logic                        ram_we, ram_re;
    logic [oiem_pkg::MSG_WIDTH-1:0] ram_rdata;
    logic                        out_free;

    assign cmd     = oiem_pkg::cmd_t'(s_command);
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    // Target slot lookup and ring occupancy.
    always_comb begin
        if (cmd == oiem_pkg::CMD_POST_OWNER) begin
            tgt_id = (owner_reg != '0) ? owner_reg : oiem_pkg::FALLBACK_TASK;
        end else begin
            tgt_id = s_task_id;
        end
        slot_ok    = (tgt_id != '0) && (int'(tgt_id) < oiem_pkg::NUM_TASKS)
                     && mask_reg[tgt_id];
        slot       = oiem_pkg::slot_t'(tgt_id);
        head_cur   = head_reg[slot];
        tail_cur   = tail_reg[slot];
        head_nx    = oiem_pkg::ring_next(head_cur);
        tail_nx    = oiem_pkg::ring_next(tail_cur);
        ring_empty = (head_cur == tail_cur);
        ring_full  = (head_nx == tail_cur);
    end

    // Command decode: status, pointer moves, store access and owner update.
    always_comb begin
        stat_next  = oiem_pkg::ST_OK;
        rdmsg_next = 1'b0;
        head_inc   = 1'b0;
        tail_inc   = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        owner_next = owner_reg;
        case (cmd)
            oiem_pkg::CMD_POST_TO, oiem_pkg::CMD_POST_OWNER: begin
                if (!slot_ok) begin
                    stat_next = oiem_pkg::ST_NORING;
                end else if (ring_full) begin
                    stat_next = oiem_pkg::ST_FULL;
                end else begin
                    ram_we   = 1'b1;
                    head_inc = 1'b1;
                end
            end
            oiem_pkg::CMD_GET, oiem_pkg::CMD_PEEK: begin
                if (!slot_ok) begin
                    stat_next = oiem_pkg::ST_NORING;
                end else if (ring_empty) begin
                    stat_next = oiem_pkg::ST_EMPTY;
                end else begin
                    ram_re     = 1'b1;
                    rdmsg_next = 1'b1;
                    tail_inc   = (cmd == oiem_pkg::CMD_GET);
                end
            end
            oiem_pkg::CMD_OWNER_REGISTER: begin
                if ((owner_reg != '0) && (owner_reg != s_task_id)) begin
                    stat_next = oiem_pkg::ST_CONFLICT;
                end else begin
                    owner_next = s_task_id;
                end
            end
            oiem_pkg::CMD_OWNER_FORCE: begin
                owner_next = s_task_id;
            end
            oiem_pkg::CMD_OWNER_CLEAR: begin
                if (owner_reg == s_task_id) begin
                    owner_next = '0;
                end
            end
            oiem_pkg::CMD_OWNER_READ: begin
                owner_next = owner_reg;
            end
            default: begin
                stat_next = oiem_pkg::ST_OK;
            end
        endcase
    end

    // Ring store: posts write at the head, reads fetch the tail entry.
    oiem_ram #(
        .WIDTH (oiem_pkg::MSG_WIDTH),
        .DEPTH (oiem_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (accept && ram_we),
        .waddr (oiem_pkg::ring_addr(slot, head_cur)),
        .wdata (s_msg_data[oiem_pkg::MSG_WIDTH-1:0]),
        .re    (accept && ram_re),
        .raddr (oiem_pkg::ring_addr(slot, tail_cur)),
        .rdata (ram_rdata)
    );

    // Configuration, owner and per-slot pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            owner_reg <= '0;
            for (int i = 0; i < oiem_pkg::NUM_TASKS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                mask_reg <= cfg_wdata;
            end
            if (accept) begin
                owner_reg <= owner_next;
                if (head_inc) begin
                    head_reg[slot] <= head_nx;
                end
                if (tail_inc) begin
                    tail_reg[slot] <= tail_nx;
                end
            end
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // Sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // A taken response is cleared unless a new one is loaded this cycle.
            if (m_valid_reg && m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        stat_reg  <= stat_next;
                        rdmsg_reg <= rdmsg_next;
                        state_reg <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= stat_reg;
                        m_msg_reg    <= rdmsg_reg
                                        ? oiem_pkg::DATA_W'(ram_rdata) : '0;
                        m_owner_reg  <= owner_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_msg_out  = m_msg_reg;
    assign m_owner_id = m_owner_reg;

endmodule

[hw/rtl/oiem_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox port checker
// Watches the ports of the mailbox top level and flags responses or
// handshake behaviour that the block must never show.
// ----------------------------------------------------------------------------
module oiem_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [oiem_pkg::STAT_W-1:0] m_status,
    input logic [oiem_pkg::DATA_W-1:0] m_msg_out,
    input logic [oiem_pkg::ID_W-1:0]   m_owner_id
);

    // Only defined status codes are ever reported.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= oiem_pkg::ST_CONFLICT))
        else $error("mailbox reported an undefined status code");

    // A response that is not a successful read carries no message.
    a_msg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != oiem_pkg::ST_OK)) |-> (m_msg_out == '0))
        else $error("message returned with a failing status");

    // One request is worked on at a time: no accept in the cycle after one.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while the previous one is in progress");

    // A stalled response holds its fields.
    a_resp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status)
                                   && $stable(m_msg_out) && $stable(m_owner_id)))
        else $error("stalled response changed or was withdrawn");

endmodule

bind owned_input_event_mailbox_top oiem_checker u_oiem_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_status   (m_status),
    .m_msg_out  (m_msg_out),
    .m_owner_id (m_owner_id)
);

[verif/owned_input_event_mailbox_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event mailbox testbench
// Drives mailbox requests and checks every response against a scoreboard.
// The scoreboard holds its own copy of the rings, pointers, owner and mask,
// and predicts each response when its request is accepted. Directed requests
// come first. Random phases under several ring masks follow, with ring fill
// and drain runs, random idling on both sides and one long response stall.
// ----------------------------------------------------------------------------
module owned_input_event_mailbox_top_test;
    import oiem_pkg::*;

    // One expected response.
    typedef struct {
        status_t             status;
        logic [DATA_W-1:0]   msg;
        logic [ID_W-1:0]     owner;
    } mb_reply_t;

    // Mailbox state mirror, response prediction and response checking.
    class mailbox_scoreboard;
        logic [MASK_W-1:0]    ring_mask;
        logic [ID_W-1:0]      owner;
        ptr_t                 wr_ptr[NUM_TASKS];
        ptr_t                 rd_ptr[NUM_TASKS];
        logic [MSG_WIDTH-1:0] ring_mem[NUM_TASKS][RING_DEPTH];
        mb_reply_t            replies_due[$];
        int                   errors;
        int                   checked;
        int                   full_seen;
        int                   conflict_seen;

        function new();
            ring_mask     = '0;
            owner         = '0;
            errors        = 0;
            checked       = 0;
            full_seen     = 0;
            conflict_seen = 0;
            foreach (wr_ptr[i]) begin
                wr_ptr[i] = '0;
                rd_ptr[i] = '0;
            end
        endfunction

        function bit has_ring(logic [ID_W-1:0] id);
            return id != '0 && int'(id) < NUM_TASKS && int'(id) < MASK_W && ring_mask[id];
        endfunction

        function ptr_t step_ptr(ptr_t p);
            return (int'(p) + 1 >= RING_DEPTH) ? ptr_t'(0) : ptr_t'(p + 1'b1);
        endfunction

        function int depth_of(logic [ID_W-1:0] id);
            return (int'(wr_ptr[id]) - int'(rd_ptr[id]) + RING_DEPTH) % RING_DEPTH;
        endfunction

        // Append a message to a task's ring, or say why it cannot be.
        function status_t deliver(logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
            ptr_t nx;
            if (!has_ring(id))
                return ST_NORING;
            nx = step_ptr(wr_ptr[id]);
            if (nx == rd_ptr[id])
                return ST_FULL;
            ring_mem[id][wr_ptr[id]] = data[MSG_WIDTH-1:0];
            wr_ptr[id] = nx;
            return ST_OK;
        endfunction

        // Read the oldest message of a task's ring, removing it if asked.
        function status_t fetch(logic [ID_W-1:0] id, bit consume,
                                output logic [DATA_W-1:0] msg);
            msg = '0;
            if (!has_ring(id))
                return ST_NORING;
            if (wr_ptr[id] == rd_ptr[id])
                return ST_EMPTY;
            msg = DATA_W'(ring_mem[id][rd_ptr[id]]);
            if (consume)
                rd_ptr[id] = step_ptr(rd_ptr[id]);
            return ST_OK;
        endfunction

        // An accepted request updates the mirror and queues its response.
        function void note_request(cmd_t cmd, logic [ID_W-1:0] id,
                                   logic [DATA_W-1:0] data);
            mb_reply_t r;
            r.status = ST_OK;
            r.msg    = '0;
            case (cmd)
                CMD_POST_TO: begin
                    r.status = deliver(id, data);
                end
                CMD_POST_OWNER: begin
                    r.status = deliver(owner != '0 ? owner : FALLBACK_TASK, data);
                end
                CMD_GET: begin
                    r.status = fetch(id, 1'b1, r.msg);
                end
                CMD_PEEK: begin
                    r.status = fetch(id, 1'b0, r.msg);
                end
                CMD_OWNER_REGISTER: begin
                    if (owner != '0 && owner != id)
                        r.status = ST_CONFLICT;
                    else
                        owner = id;
                end
                CMD_OWNER_FORCE: begin
                    owner = id;
                end
                CMD_OWNER_CLEAR: begin
                    if (owner == id)
                        owner = '0;
                end
                default: begin
                end
            endcase
            r.owner = owner;
            replies_due.push_back(r);
        endfunction

        task report(string what);
            if (errors < 40)
                $display("[%0t] MISMATCH: %s", $time, what);
            errors++;
        endtask

        // Compare one accepted response with the oldest expectation.
        task check_reply(logic [STAT_W-1:0] st, logic [DATA_W-1:0] msg,
                         logic [ID_W-1:0] own);
            mb_reply_t r;
            if (replies_due.size() == 0) begin
                report($sformatf("response with nothing outstanding, status %0d", st));
                return;
            end
            r = replies_due.pop_front();
            checked++;
            if (st !== r.status)
                report($sformatf("status %0d, expected %0d", st, r.status));
            if (msg !== r.msg)
                report($sformatf("msg_out %h, expected %h", msg, r.msg));
            if (own !== r.owner)
                report($sformatf("owner_id %0d, expected %0d", own, r.owner));
            if (r.status == ST_FULL)
                full_seen++;
            if (r.status == ST_CONFLICT)
                conflict_seen++;
        endtask
    endclass

    // Clock, reset and block inputs, all known from time zero.
    logic              aclk       = 1'b0;
    logic              aresetn    = 1'b0;
    logic              cfg_we     = 1'b0;
    logic [MASK_W-1:0] cfg_wdata  = '0;
    logic              s_valid    = 1'b0;
    logic [CMD_W-1:0]  s_command  = '0;
    logic [ID_W-1:0]   s_task_id  = '0;
    logic [DATA_W-1:0] s_msg_data = '0;
    logic              m_ready    = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [STAT_W-1:0] m_status;
    logic [DATA_W-1:0] m_msg_out;
    logic [ID_W-1:0]   m_owner_id;

    mailbox_scoreboard sb = new();
    bit quiet         = 1'b0;
    bit long_hold_req = 1'b0;
    int masks_used    = 0;
    int sent          = 0;

    owned_input_event_mailbox_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_task_id  (s_task_id),
        .s_msg_data (s_msg_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_msg_out  (m_msg_out),
        .m_owner_id (m_owner_id)
    );

    always #5 aclk = ~aclk;

    // Safety net against a hung handshake.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Response side: check each accepted response, then choose the next ready.
    initial begin : responder
        int stall_left;
        bit ready_next;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_reply(m_status, m_msg_out, m_owner_id);
            if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (long_hold_req) begin
                // Long hold so that the block backs up and stalls its input.
                long_hold_req = 1'b0;
                stall_left    = 59;
                ready_next    = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_ready <= ready_next;
        end
    end

    // Offer one request and wait for it to be accepted.
    task send_request(cmd_t cmd, logic [ID_W-1:0] id, logic [DATA_W-1:0] data);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_task_id  <= id;
        s_msg_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(cmd, id, data);
        sent++;
    endtask

    // Stop offering and wait until every response has been taken.
    task wait_idle();
        s_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_mask(logic [MASK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we       <= 1'b0;
        sb.ring_mask  = value;
        masks_used++;
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '1;
        if (r == 1)
            return '0;
        return {$urandom(), $urandom()};
    endfunction

    // Mostly a task that has a ring; any id when none is found.
    function automatic logic [ID_W-1:0] pick_task();
        logic [ID_W-1:0] id;
        for (int k = 0; k < 32; k++) begin
            id = ID_W'($urandom_range(1, 15));
            if (sb.has_ring(id))
                return id;
        end
        return ID_W'($urandom_range(0, 15));
    endfunction

    // Push one ring past full, then read it back with one more get or peek than it holds.
    task fill_and_drain();
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] owner_target;
        int n;
        id = pick_task();
        if (!sb.has_ring(id))
            return;
        n = RING_DEPTH - sb.depth_of(id) + $urandom_range(0, 4);
        repeat (n) begin
            owner_target = (sb.owner != '0) ? sb.owner : FALLBACK_TASK;
            if (owner_target == id && $urandom_range(0, 1) == 1)
                send_request(CMD_POST_OWNER, id, pick_data());
            else
                send_request(CMD_POST_TO, id, pick_data());
        end
        n = sb.depth_of(id) + 1;
        repeat (n)
            send_request($urandom_range(0, 5) == 0 ? CMD_PEEK : CMD_GET, id, pick_data());
    endtask

    task random_item();
        int r;
        cmd_t cmd;
        logic [ID_W-1:0] id;
        r = $urandom_range(0, 99);
        if (r < 30)
            cmd = CMD_POST_TO;
        else if (r < 40)
            cmd = CMD_POST_OWNER;
        else if (r < 62)
            cmd = CMD_GET;
        else if (r < 72)
            cmd = CMD_PEEK;
        else if (r < 80)
            cmd = CMD_OWNER_REGISTER;
        else if (r < 87)
            cmd = CMD_OWNER_FORCE;
        else if (r < 94)
            cmd = CMD_OWNER_CLEAR;
        else
            cmd = CMD_OWNER_READ;
        if (cmd >= CMD_OWNER_REGISTER || $urandom_range(0, 6) == 0)
            id = ID_W'($urandom_range(0, 15));
        else
            id = pick_task();
        send_request(cmd, id, pick_data());
    endtask

    // Random requests, with the odd fill and drain run mixed in.
    task random_phase(int budget);
        int done;
        int start_count;
        done = 0;
        while (done < budget) begin
            if ($urandom_range(0, 59) == 0) begin
                start_count = sent;
                fill_and_drain();
                done += sent - start_count;
            end else begin
                random_item();
                done++;
            end
        end
    endtask

    // Main sequence.
    initial begin : main_seq
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No rings at all: every ring request is refused.
        write_mask(16'h0000);
        send_request(CMD_POST_TO, 4'd3, 64'h0123_4567_89AB_CDEF);
        send_request(CMD_GET, 4'd3, '0);
        send_request(CMD_POST_OWNER, 4'd0, 64'hDEAD_BEEF_0000_0001);
        send_request(CMD_OWNER_READ, 4'd0, '0);
        wait_idle();

        // Every slot has a ring; task zero is still refused.
        write_mask(16'hFFFF);
        send_request(CMD_POST_TO, 4'd0, 64'h5555_AAAA_5555_AAAA);
        send_request(CMD_GET, 4'd0, '0);
        send_request(CMD_POST_TO, 4'd15, '1);
        send_request(CMD_POST_TO, 4'd15, '0);
        send_request(CMD_PEEK, 4'd15, '0);
        send_request(CMD_GET, 4'd15, '0);
        send_request(CMD_GET, 4'd15, '0);
        send_request(CMD_GET, 4'd15, '1);
        send_request(CMD_PEEK, 4'd15, '0);
        // Owner posts fall back to task 1 while no owner is set.
        send_request(CMD_POST_OWNER, 4'd7, 64'hA5A5_0000_FFFF_1234);
        send_request(CMD_GET, 4'd1, '0);
        // Register, conflict, re-register and owner-directed posting.
        send_request(CMD_OWNER_REGISTER, 4'd5, '0);
        send_request(CMD_OWNER_REGISTER, 4'd6, '0);
        send_request(CMD_OWNER_REGISTER, 4'd5, '0);
        send_request(CMD_POST_OWNER, 4'd2, 64'h8000_0000_0000_0001);
        send_request(CMD_GET, 4'd5, '0);
        send_request(CMD_OWNER_CLEAR, 4'd6, '0);
        send_request(CMD_OWNER_CLEAR, 4'd5, '0);
        send_request(CMD_OWNER_FORCE, 4'd9, '0);
        send_request(CMD_OWNER_REGISTER, 4'd0, '0);
        send_request(CMD_OWNER_FORCE, 4'd0, '0);
        send_request(CMD_OWNER_REGISTER, 4'd0, '0);
        send_request(CMD_OWNER_READ, 4'd15, '0);
        wait_idle();

        // Random phases; ring contents carry over each mask change.
        long_hold_req = 1'b1;
        random_phase(230);
        wait_idle();
        write_mask(MASK_W'($urandom_range(0, 16'hFFFF)));
        random_phase(200);
        wait_idle();
        write_mask(16'h8002);
        random_phase(150);
        wait_idle();
        write_mask(16'h0000);
        random_phase(50);
        wait_idle();
        write_mask(MASK_W'($urandom_range(0, 16'hFFFF)));
        random_phase(200);
        wait_idle();
        // Final stretch at full rate on both sides.
        write_mask(16'hFFFF);
        quiet = 1'b1;
        random_phase(150);
        wait_idle();
        repeat (8) @(posedge aclk);

        if (sb.replies_due.size() != 0)
            sb.report($sformatf("%0d responses never arrived", sb.replies_due.size()));
        $display("Covered %0d requests under %0d ring masks; %0d responses checked.",
                 sent, masks_used, sb.checked);
        $display("Saw %0d posts dropped on a full ring and %0d owner conflicts.",
                 sb.full_seen, sb.conflict_seen);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/oiem_pkg.sv
hw/rtl/oiem_ram.sv
hw/rtl/owned_input_event_mailbox_top.sv
hw/rtl/oiem_checker.sv
verif/owned_input_event_mailbox_top_test.sv
